// File: rtl/uvdf_pkg.sv
// Shared types and constants for the UTF-8 Vietnamese diacritic fold block.
package uvdf_pkg;

  // Code point width covers 0x000000..0x1FFFFF
  localparam int CP_W = 21;

  // Sequence length codes (continuation bytes of the whole sequence)
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO  = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR = 2'd3;

  // Range limits checked when a sequence completes
  localparam logic [CP_W-1:0] MIN_TWO      = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR     = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

  // Base letters of the fold
  localparam logic [7:0] LETTER_A = 8'h61;
  localparam logic [7:0] LETTER_D = 8'h64;
  localparam logic [7:0] LETTER_E = 8'h65;
  localparam logic [7:0] LETTER_I = 8'h69;
  localparam logic [7:0] LETTER_O = 8'h6F;
  localparam logic [7:0] LETTER_U = 8'h75;
  localparam logic [7:0] LETTER_Y = 8'h79;

  // Decoder result handed to the fold stage
  typedef struct packed {
    logic            valid;
    logic            err;
    logic            last;
    logic [CP_W-1:0] cp;
  } dec_res_t;

  // Finished result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       unmapped_wide;
    logic       decode_error;
    logic       end_of_text;
  } res_t;

endpackage

// File: rtl/uvdf_if.sv
// Handshake channels for byte input and folded character output.
interface uvdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface uvdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       unmapped_wide;
  logic       decode_error;
  logic       end_of_text;

  modport source (output valid, output out_byte, output unmapped_wide,
                  output decode_error, output end_of_text, input ready);
  modport sink (input valid, input out_byte, input unmapped_wide,
                input decode_error, input end_of_text, output ready);
endinterface

// File: rtl/uvdf_decode.sv
// UTF-8 sequence decoder: holds partial state and validates each sequence.
module uvdf_decode
  import uvdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       last,
  output dec_res_t   res
);

  logic [CP_W-1:0] partial_code_point;
  logic [1:0]      bytes_remaining;
  logic [1:0]      sequence_length;

  logic [CP_W-1:0] partial_code_point_next;
  logic [1:0]      bytes_remaining_next;
  logic [1:0]      sequence_length_next;

  logic [CP_W-1:0] shifted;
  logic [1:0]      rem_dec;
  logic            too_small;
  logic            fail;
  logic            done;

  assign shifted = {partial_code_point[CP_W-7:0], in_byte[5:0]};
  assign rem_dec = bytes_remaining - 2'd1;

  // Minimum value for the sequence length; surrogate and ceiling are checked below
  always_comb begin
    case (sequence_length)
      SEQ_TWO:   too_small = shifted < MIN_TWO;
      SEQ_THREE: too_small = shifted < MIN_THREE;
      SEQ_FOUR:  too_small = shifted < MIN_FOUR;
      default:   too_small = 1'b0;
    endcase
  end

  // Classify the byte against the decoder state
  always_comb begin
    fail = 1'b0;
    done = 1'b0;
    res.cp = {{(CP_W-8){1'b0}}, in_byte};
    partial_code_point_next = partial_code_point;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    if (bytes_remaining == 2'd0) begin
      if (!in_byte[7]) begin
        done = 1'b1;
      end else if (in_byte[7:6] == 2'b10 || in_byte[7:3] == 5'b11111) begin
        fail = 1'b1;
      end else if (last) begin
        fail = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        partial_code_point_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
        sequence_length_next = SEQ_TWO;
        bytes_remaining_next = SEQ_TWO;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_code_point_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
        sequence_length_next = SEQ_THREE;
        bytes_remaining_next = SEQ_THREE;
      end else begin
        partial_code_point_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
        sequence_length_next = SEQ_FOUR;
        bytes_remaining_next = SEQ_FOUR;
      end
    end else if (in_byte[7:6] != 2'b10) begin
      fail = 1'b1;
    end else if (rem_dec != 2'd0) begin
      if (last) begin
        fail = 1'b1;
      end else begin
        partial_code_point_next = shifted;
        bytes_remaining_next = rem_dec;
      end
    end else if (too_small || (shifted >= SURR_LO && shifted <= SURR_HI) ||
                 shifted > CP_MAX) begin
      fail = 1'b1;
    end else begin
      done = 1'b1;
      res.cp = shifted;
      partial_code_point_next = '0;
      bytes_remaining_next = SEQ_NONE;
      sequence_length_next = SEQ_NONE;
    end
    // Drop any partial sequence on error
    if (fail) begin
      partial_code_point_next = '0;
      bytes_remaining_next = SEQ_NONE;
      sequence_length_next = SEQ_NONE;
    end
    res.valid = fail || done;
    res.err = fail;
    res.last = last;
  end

  // Advance the decoder state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code_point <= '0;
      bytes_remaining <= SEQ_NONE;
      sequence_length <= SEQ_NONE;
    end else if (step) begin
      partial_code_point <= partial_code_point_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

// File: rtl/uvdf_fold.sv
// Fold of decoded code points to base letters and result formatting.
module uvdf_fold
  import uvdf_pkg::*;
(
  input  dec_res_t dec,
  output res_t     res
);

  logic [7:0] letter;
  logic       hit;

  // Look up the diacritic table
  always_comb begin
    hit = 1'b1;
    case (dec.cp)
      21'h0000E0, 21'h0000E1, 21'h001EA3, 21'h001EA1, 21'h0000E3, 21'h0000E2,
      21'h001EA7, 21'h001EA5, 21'h001EA9, 21'h001EAD, 21'h001EAB, 21'h000103,
      21'h001EB1, 21'h001EAF, 21'h001EB3, 21'h001EB7, 21'h001EB5,
      21'h0000C0, 21'h0000C1, 21'h001EA2, 21'h001EA0, 21'h0000C3, 21'h0000C2,
      21'h001EA6, 21'h001EA4, 21'h001EA8, 21'h001EAC, 21'h001EAA, 21'h000102,
      21'h001EB0, 21'h001EAE, 21'h001EB2, 21'h001EB6, 21'h001EB4:
        letter = LETTER_A;
      21'h0000E8, 21'h0000E9, 21'h001EBB, 21'h001EB9, 21'h001EBD, 21'h0000EA,
      21'h001EC1, 21'h001EBF, 21'h001EC3, 21'h001EC7, 21'h001EC5,
      21'h0000C8, 21'h0000C9, 21'h001EBA, 21'h001EB8, 21'h001EBC, 21'h0000CA,
      21'h001EC0, 21'h001EBE, 21'h001EC2, 21'h001EC6, 21'h001EC4:
        letter = LETTER_E;
      21'h0000EC, 21'h0000ED, 21'h001EC9, 21'h001ECB, 21'h000129,
      21'h0000CC, 21'h0000CD, 21'h001EC8, 21'h001ECA, 21'h000128:
        letter = LETTER_I;
      21'h0000F2, 21'h0000F3, 21'h001ECF, 21'h001ECD, 21'h0000F5, 21'h0000F4,
      21'h001ED3, 21'h001ED1, 21'h001ED5, 21'h001ED9, 21'h001ED7, 21'h0001A1,
      21'h001EDD, 21'h001EDB, 21'h001EDF, 21'h001EE3, 21'h001EE1,
      21'h0000D2, 21'h0000D3, 21'h001ECE, 21'h001ECC, 21'h0000D5, 21'h0000D4,
      21'h001ED2, 21'h001ED0, 21'h001ED4, 21'h001ED8, 21'h001ED6, 21'h0001A0,
      21'h001EDC, 21'h001EDA, 21'h001EDE, 21'h001EE2, 21'h001EE0:
        letter = LETTER_O;
      21'h0000F9, 21'h0000FA, 21'h001EE7, 21'h001EE5, 21'h000169, 21'h0001B0,
      21'h001EEB, 21'h001EE9, 21'h001EED, 21'h001EF1, 21'h001EEF,
      21'h0000D9, 21'h0000DA, 21'h001EE6, 21'h001EE4, 21'h000168, 21'h0001AF,
      21'h001EEA, 21'h001EE8, 21'h001EEC, 21'h001EF0, 21'h001EEE:
        letter = LETTER_U;
      21'h001EF3, 21'h0000FD, 21'h001EF7, 21'h001EF5, 21'h001EF9,
      21'h001EF2, 21'h0000DD, 21'h001EF6, 21'h001EF4, 21'h001EF8:
        letter = LETTER_Y;
      21'h000111, 21'h000110:
        letter = LETTER_D;
      default: begin
        letter = dec.cp[7:0];
        hit = 1'b0;
      end
    endcase
  end

  // Format the result; an error carries a zero byte
  always_comb begin
    res.end_of_text = dec.last;
    res.decode_error = dec.err;
    if (dec.err) begin
      res.out_byte = 8'h00;
      res.unmapped_wide = 1'b0;
    end else begin
      res.out_byte = letter;
      res.unmapped_wide = !hit && (dec.cp[CP_W-1:7] != '0);
    end
  end

endmodule

// File: rtl/utf8_vietnamese_diacritic_fold.sv
// Top level: input register, UTF-8 decode and fold, result register.
//
// Takes one UTF-8 byte per transfer and gives at most one result per byte:
// a folded letter (Vietnamese vowels with diacritics in either case become
// a, e, i, o, u or y; U+0110/U+0111 become d), otherwise the low 8 bits of
// the code point with unmapped_wide set above 0x7F, or an error flag with a
// zero byte for malformed or truncated input. Lead and middle bytes of a
// valid sequence give no result. A byte is accepted every cycle while
// results drain. It is held in the input register, and its result is loaded
// into the result register and offered on char_out from there. A result that
// waits on char_out.ready holds the input register, and the input stalls once
// both registers are full. The decode plus table lookup between them is the
// only logic on that path.
module utf8_vietnamese_diacritic_fold
  import uvdf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  uvdf_in_if.sink    byte_in,
  uvdf_out_if.source char_out
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  res_t       out_res;
  logic       out_free;
  logic       step;
  dec_res_t   dec;
  res_t       fold_res;

  assign out_free = !out_valid || char_out.ready;
  assign step = in_valid && out_free;
  assign byte_in.ready = !in_valid || out_free;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.in_byte;
      in_last <= byte_in.last;
    end
  end

  uvdf_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .last    (in_last),
    .res     (dec)
  );

  uvdf_fold u_fold (
    .dec (dec),
    .res (fold_res)
  );

  // Load a result when the byte produces one; clear after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && dec.valid) begin
      out_valid <= 1'b1;
    end else if (char_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && dec.valid) begin
      out_res <= fold_res;
    end
  end

  assign char_out.valid = out_valid;
  assign char_out.out_byte = out_res.out_byte;
  assign char_out.unmapped_wide = out_res.unmapped_wide;
  assign char_out.decode_error = out_res.decode_error;
  assign char_out.end_of_text = out_res.end_of_text;

endmodule

// File: tb/sv/utf8_vietnamese_diacritic_fold_test.sv
// Self-checking bench for the UTF-8 decoder with Vietnamese diacritic folding.
module utf8_vietnamese_diacritic_fold_test;
  import uvdf_pkg::*;

  localparam int ITEM_GOAL   = 1350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 400;
  localparam int PAUSE_AT    = 850;
  localparam int CALM_TAIL   = 150;

  // Track decoder state, predict each folded character, compare in order
  class fold_scoreboard;
    logic [CP_W-1:0] gathered_cp;
    logic [1:0]      conts_left;
    logic [1:0]      seq_len;
    res_t            due_chars[$];
    int              mismatches;
    int              matched;
    int              folded_cnt;
    int              wide_cnt;
    int              error_cnt;

    function new();
      go_idle();
      mismatches = 0;
      matched    = 0;
      folded_cnt = 0;
      wide_cnt   = 0;
      error_cnt  = 0;
    endfunction

    function void go_idle();
      gathered_cp = '0;
      conts_left  = SEQ_NONE;
      seq_len     = SEQ_NONE;
    endfunction

    // Map a code point to its base letter; zero when it does not fold
    function logic [7:0] base_letter(input logic [CP_W-1:0] cp);
      logic [7:0] letter;
      letter = 8'h00;
      case (cp)
        21'h00C0, 21'h00C1, 21'h00C2, 21'h00C3, 21'h00E0, 21'h00E1, 21'h00E2, 21'h00E3,
        21'h0102, 21'h0103: letter = LETTER_A;
        21'h00C8, 21'h00C9, 21'h00CA, 21'h00E8, 21'h00E9, 21'h00EA: letter = LETTER_E;
        21'h00CC, 21'h00CD, 21'h00EC, 21'h00ED, 21'h0128, 21'h0129: letter = LETTER_I;
        21'h00D2, 21'h00D3, 21'h00D4, 21'h00D5, 21'h00F2, 21'h00F3, 21'h00F4, 21'h00F5,
        21'h01A0, 21'h01A1: letter = LETTER_O;
        21'h00D9, 21'h00DA, 21'h00F9, 21'h00FA, 21'h0168, 21'h0169,
        21'h01AF, 21'h01B0: letter = LETTER_U;
        21'h00DD, 21'h00FD: letter = LETTER_Y;
        21'h0110, 21'h0111: letter = LETTER_D;
        default: begin
          // Latin Extended Additional vowels sit in contiguous runs
          if (cp >= 21'h1EA0 && cp <= 21'h1EB7) letter = LETTER_A;
          else if (cp >= 21'h1EB8 && cp <= 21'h1EC7) letter = LETTER_E;
          else if (cp >= 21'h1EC8 && cp <= 21'h1ECB) letter = LETTER_I;
          else if (cp >= 21'h1ECC && cp <= 21'h1EE3) letter = LETTER_O;
          else if (cp >= 21'h1EE4 && cp <= 21'h1EF1) letter = LETTER_U;
          else if (cp >= 21'h1EF2 && cp <= 21'h1EF9) letter = LETTER_Y;
        end
      endcase
      return letter;
    endfunction

    function res_t fold_char(input logic [CP_W-1:0] cp, input logic l);
      res_t r;
      logic [7:0] letter;
      letter          = base_letter(cp);
      r.decode_error  = 1'b0;
      r.end_of_text   = l;
      if (letter != 8'h00) begin
        r.out_byte      = letter;
        r.unmapped_wide = 1'b0;
        folded_cnt++;
      end else begin
        r.out_byte      = cp[7:0];
        r.unmapped_wide = (cp > 21'h00007F);
        if (r.unmapped_wide) wide_cnt++;
      end
      return r;
    endfunction

    function res_t decode_fault(input logic l);
      res_t r;
      go_idle();
      r              = '0;
      r.decode_error = 1'b1;
      r.end_of_text  = l;
      error_cnt++;
      return r;
    endfunction

    // Advance the decoder by one accepted byte and queue any result
    function void note_byte(input logic [7:0] b, input logic l);
      res_t            r;
      logic            emit;
      logic [CP_W-1:0] floor_cp;
      emit = 1'b0;
      r    = '0;
      if (conts_left == SEQ_NONE) begin
        if (b < 8'h80) begin
          r    = fold_char({13'd0, b}, l);
          emit = 1'b1;
        end else if (b < 8'hC0 || b >= 8'hF8) begin
          r    = decode_fault(l);
          emit = 1'b1;
        end else begin
          if (b < 8'hE0) begin
            gathered_cp = {16'd0, b[4:0]};
            seq_len     = SEQ_TWO;
          end else if (b < 8'hF0) begin
            gathered_cp = {17'd0, b[3:0]};
            seq_len     = SEQ_THREE;
          end else begin
            gathered_cp = {18'd0, b[2:0]};
            seq_len     = SEQ_FOUR;
          end
          conts_left = seq_len;
          if (l) begin
            r    = decode_fault(l);
            emit = 1'b1;
          end
        end
      end else if (b[7:6] != 2'b10) begin
        r    = decode_fault(l);
        emit = 1'b1;
      end else begin
        gathered_cp = {gathered_cp[CP_W-7:0], b[5:0]};
        conts_left  = conts_left - 2'd1;
        if (conts_left != SEQ_NONE) begin
          if (l) begin
            r    = decode_fault(l);
            emit = 1'b1;
          end
        end else begin
          case (seq_len)
            SEQ_TWO:   floor_cp = MIN_TWO;
            SEQ_THREE: floor_cp = MIN_THREE;
            default:   floor_cp = MIN_FOUR;
          endcase
          if (gathered_cp < floor_cp || gathered_cp > CP_MAX ||
              (gathered_cp >= SURR_LO && gathered_cp <= SURR_HI)) begin
            r = decode_fault(l);
          end else begin
            r = fold_char(gathered_cp, l);
            go_idle();
          end
          emit = 1'b1;
        end
      end
      if (emit) due_chars.push_back(r);
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_char(input res_t got);
      res_t want;
      if (due_chars.size() == 0) begin
        $error("unexpected result: out_byte %0h decode_error %0b", got.out_byte,
               got.decode_error);
        mismatches++;
        return;
      end
      want = due_chars.pop_front();
      matched++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.unmapped_wide !== want.unmapped_wide) begin
        $error("unmapped_wide: expected %0b, got %0b", want.unmapped_wide, got.unmapped_wide);
        mismatches++;
      end
      if (got.decode_error !== want.decode_error) begin
        $error("decode_error: expected %0b, got %0b", want.decode_error, got.decode_error);
        mismatches++;
      end
      if (got.end_of_text !== want.end_of_text) begin
        $error("end_of_text: expected %0b, got %0b", want.end_of_text, got.end_of_text);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   bytes_sent  = 0;
  int   cycle_count = 0;
  bit   idle_on     = 1'b1;
  bit   hold_req    = 1'b0;
  bit   hold_active = 1'b0;
  logic [7:0] text_q[$];

  fold_scoreboard board = new();

  uvdf_in_if  in_ch();
  uvdf_out_if out_ch();

  utf8_vietnamese_diacritic_fold dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (in_ch),
    .char_out (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Feed the scoreboard from both channels
  always @(posedge clk) begin : watch_ports
    res_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_byte(in_ch.in_byte, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte      = out_ch.out_byte;
        got.unmapped_wide = out_ch.unmapped_wide;
        got.decode_error  = out_ch.decode_error;
        got.end_of_text   = out_ch.end_of_text;
        board.check_char(got);
      end
    end
  end

  // Drive ready: random stalls, one long hold on request
  initial begin : sink_side
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req     = 1'b0;
        hold_active  = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active  = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offer one byte, with an optional idle burst first, and hold until transfer
  task automatic send_byte(input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.last    <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stop offering and wait for every predicted result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.due_chars.size() != 0);
  endtask

  // Send the queued string, marking its final byte
  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Encode a code point in the given number of bytes, overlong if asked
  task automatic add_utf8(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: text_q.push_back(cp[7:0]);
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Push a lead byte and fewer continuations than it needs
  task automatic add_partial();
    int   n;
    int   k;
    int   j;
    logic [7:0] lead;
    n    = $urandom_range(2, 4);
    lead = 8'($urandom_range(0, 255));
    case (n)
      2:       lead = {3'b110, lead[4:0]};
      3:       lead = {4'b1110, lead[3:0]};
      default: lead = {5'b11110, lead[2:0]};
    endcase
    text_q.push_back(lead);
    k = $urandom_range(0, n - 2);
    for (j = 0; j < k; j++) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // Add one character of random text, mostly well formed
  task automatic add_random_unit(output bit cut);
    int   pick;
    int   n;
    logic [20:0] cp;
    logic [7:0]  b;
    cut  = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      text_q.push_back(8'($urandom_range(0, 127)));
    end else if (pick < 55) begin
      // Land on or near the folded letters
      case ($urandom_range(0, 3))
        0, 1:    cp = 21'h00C0 + 21'($urandom_range(0, 63));
        2:       cp = 21'h0100 + 21'($urandom_range(0, 'hB0));
        default: cp = 21'h1EA0 + 21'($urandom_range(0, 'h5F));
      endcase
      add_utf8(cp, natural_len(cp));
    end else if (pick < 62) begin
      add_utf8(21'($urandom_range('h80, 'h7FF)), 2);
    end else if (pick < 72) begin
      add_utf8(21'($urandom_range('h800, 'hFFFF)), 3);
    end else if (pick < 80) begin
      add_utf8(21'($urandom_range('h10000, 'h10FFFF)), 4);
    end else begin
      case ($urandom_range(0, 7))
        0: text_q.push_back(8'($urandom_range('h80, 'hBF)));
        1: text_q.push_back(8'($urandom_range('hF8, 'hFF)));
        2: begin
          n = $urandom_range(2, 4);
          cp = (n == 2) ? 21'($urandom_range(0, 'h7F)) :
               (n == 3) ? 21'($urandom_range(0, 'h7FF)) : 21'($urandom_range(0, 'hFFFF));
          add_utf8(cp, n);
        end
        3: add_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
        4: add_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        5: begin
          add_partial();
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b = b ^ 8'h40;
          text_q.push_back(b);
        end
        default: begin
          add_partial();
          cut = 1'b1;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int units;
    int u;
    int j;
    bit cut;
    bit hold_done;
    bit pause_done;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.last    <= 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Field extremes and plain ASCII
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // Folded vowel, folded d, folded letter from the extended block
    send_byte(8'hC3, 1'b0); send_byte(8'hA0, 1'b0);
    send_byte(8'hC4, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'hE1, 1'b0); send_byte(8'hBB, 1'b0); send_byte(8'h87, 1'b0);
    // Unfolded four-byte code point
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // Stray continuation, invalid lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Overlong, surrogate, above the Unicode range
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // Broken sequence, then truncation on the final byte
    send_byte(8'hE1, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b1);

    // Random strings
    while (bytes_sent < ITEM_GOAL) begin
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        // Fill the block while the output is held off
        hold_done = 1'b1;
        hold_req  = 1'b1;
        while (!hold_active) @(posedge clk);
        for (j = 0; j < 48; j++) send_byte(8'($urandom_range(0, 127)), 1'b0);
      end
      if (!pause_done && bytes_sent >= PAUSE_AT) begin
        pause_done = 1'b1;
        wait_drained();
      end
      if (bytes_sent >= ITEM_GOAL - CALM_TAIL) idle_on = 1'b0;
      units = $urandom_range(1, 10);
      cut   = 1'b0;
      for (u = 0; u < units && !cut; u++) add_random_unit(cut);
      send_text();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes; checked %0d results: %0d folded, %0d wide, %0d decode errors.",
             bytes_sent, board.matched, board.folded_cnt, board.wide_cnt, board.error_cnt);
    $display("Mismatches: %0d, results still outstanding: %0d.", board.mismatches,
             board.due_chars.size());
    if (board.mismatches == 0 && board.due_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
